// ----- src/q2e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int DEF_CORDIC_STEPS = 16;
   localparam int DEF_DATA_WIDTH   = 16;

   // angle accumulator: Q.30 radians, wide enough for +-pi plus CORDIC overshoot
   localparam int ANG_W = 34;
   // CORDIC x/y working width: |args| < 2^31, gain 1.65 plus headroom
   localparam int CX_W = 36;

   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam int ANG_FRAC = 30;

   // Q.28 products of Q2.14 operands, plus growth for out-of-range inputs
   localparam int PROD_W = 36;
   localparam logic signed [PROD_W-1:0] ONE_Q28 = 36'sd268435456;

   // radicand 2^56 - s^2 and root widths
   localparam int RAD_W  = 58;
   localparam int ROOT_W = 29;

   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] t [32];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
            32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
            32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
            32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
            32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
            32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
            32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000};
      return t[idx];
   endfunction

   // one CORDIC lane: vector plus angle
   typedef struct packed {
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } lane_type;

endpackage
`default_nettype wire

// ----- src/quaternion_to_euler_angles.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Quaternion (w,x,y,z) to ZYX roll/pitch/yaw.
// Stages from start to rsp_valid: products, sums, square, radicand, square root digits,
//   CORDIC quadrant fold and steps, then round/limit.
// Throughput: one item per cycle; busy is tied low, every stage is a plain pipeline.
// Reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall: each result shows for one cycle under rsp_valid.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = q2e_pkg::DEF_CORDIC_STEPS,
   parameter int DATA_WIDTH   = q2e_pkg::DEF_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DATA_WIDTH-1:0] req_quat_w,
   input  wire logic [DATA_WIDTH-1:0] req_quat_x,
   input  wire logic [DATA_WIDTH-1:0] req_quat_y,
   input  wire logic [DATA_WIDTH-1:0] req_quat_z,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_roll_angle,
   output logic [DATA_WIDTH-2:0]      rsp_pitch_angle,
   output logic [DATA_WIDTH-1:0]      rsp_yaw_angle,
   output logic                       rsp_pitch_clamped
);
   import q2e_pkg::*;

   localparam int SH = ANG_FRAC - (DATA_WIDTH - 3);
   localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (SH - 1);
   localparam logic signed [ANG_W-1:0] PI_O   = (PI_Q30 + HALF) >>> SH;
   localparam logic signed [ANG_W-1:0] HPI_O  = (HALF_PI_Q30 + HALF) >>> SH;
   localparam logic signed [ANG_W-1:0] NHPI_O = -HPI_O;

   // never stall the source
   assign busy = 1'b0;

   logic fv;
   logic signed [PROD_W-1:0] ry, rx, yy, yx, s;
   q2e_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset, .in_valid(start),
      .quat_w(req_quat_w), .quat_x(req_quat_x), .quat_y(req_quat_y), .quat_z(req_quat_z),
      .out_valid(fv), .roll_y(ry), .roll_x(rx), .yaw_y(yy), .yaw_x(yx), .sine(s));

   logic sv, clamp;
   lane_type rl, yl, pl;
   q2e_sqrt u_sqrt (
      .clock, .reset, .in_valid(fv), .roll_y(ry), .roll_x(rx), .yaw_y(yy),
      .yaw_x(yx), .sine(s), .out_valid(sv), .roll_lane(rl), .yaw_lane(yl),
      .pitch_lane(pl), .pitch_clamp(clamp));

   // three CORDIC lanes run in lockstep
   logic cv_r, cv_y, cv_p;
   logic signed [ANG_W-1:0] a_r, a_y, a_p;
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock, .reset, .in_valid(sv), .lane_in(rl), .out_valid(cv_r), .angle(a_r));
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock, .reset, .in_valid(sv), .lane_in(yl), .out_valid(cv_y), .angle(a_y));
   q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock, .reset, .in_valid(sv), .lane_in(pl), .out_valid(cv_p), .angle(a_p));

   // carry the clamp flag and the pitch sine sign alongside the CORDIC lanes
   localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   logic [NS:0] cl_ff;
   logic        sgn_ff [NS+1];
   always_ff @(posedge clock) begin
      cl_ff[0]  <= clamp;
      sgn_ff[0] <= !pl.y[CX_W-1];
      for (int i = 0; i < NS; i++) begin
         cl_ff[i+1]  <= cl_ff[i];
         sgn_ff[i+1] <= sgn_ff[i];
      end
   end

   function automatic logic signed [ANG_W-1:0] lim(input logic signed [ANG_W-1:0] a,
                                                   input logic signed [ANG_W-1:0] l);
      logic signed [ANG_W-1:0] r;
      r = (a + HALF) >>> SH;
      if (r > l)       return l;
      else if (r < -l) return -l;
      else             return r;
   endfunction

   logic signed [ANG_W-1:0] roll_in, yaw_in, pitch_in;
   logic [DATA_WIDTH-1:0] roll_ff, yaw_ff;
   logic [DATA_WIDTH-2:0] pitch_ff;
   logic valid_ff, clamp_ff;

   always_comb begin
      roll_in = lim(a_r, PI_O);
      yaw_in  = lim(a_y, PI_O);
      if (cl_ff[NS]) pitch_in = sgn_ff[NS] ? HPI_O : -HPI_O;
      else           pitch_in = lim(a_p, HPI_O);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cv_r;
      roll_ff  <= roll_in[DATA_WIDTH-1:0];
      yaw_ff   <= yaw_in[DATA_WIDTH-1:0];
      pitch_ff <= pitch_in[DATA_WIDTH-2:0];
      clamp_ff <= cl_ff[NS];
   end

   assign rsp_valid         = valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_pitch_clamped = clamp_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (cv_r == cv_y) && (cv_r == cv_p)) else $error("cordic lanes out of step");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      sv |-> $past(fv, 31)) else $error("sqrt valid without front valid");
   a_clamp_pitch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
      (rsp_pitch_angle == HPI_O[DATA_WIDTH-2:0] ||
       rsp_pitch_angle == NHPI_O[DATA_WIDTH-2:0]))
      else $error("clamped pitch not at +-pi/2");
endmodule
`default_nettype wire

// ----- src/q2e_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: normalize to Q2.14, form the atan2 arguments and the pitch sine.
// Two register stages: products, then sums.
module q2e_front #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [DATA_WIDTH-1:0] quat_w,
   input  wire logic [DATA_WIDTH-1:0] quat_x,
   input  wire logic [DATA_WIDTH-1:0] quat_y,
   input  wire logic [DATA_WIDTH-1:0] quat_z,
   output logic                       out_valid,
   output logic signed [q2e_pkg::PROD_W-1:0] roll_y,
   output logic signed [q2e_pkg::PROD_W-1:0] roll_x,
   output logic signed [q2e_pkg::PROD_W-1:0] yaw_y,
   output logic signed [q2e_pkg::PROD_W-1:0] yaw_x,
   output logic signed [q2e_pkg::PROD_W-1:0] sine
);
   import q2e_pkg::*;

   logic signed [16:0] w_q, x_q, y_q, z_q;
   logic signed [33:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;
   logic v1_ff, v2_ff;
   logic signed [PROD_W-1:0] ry_ff, rx_ff, yy2_ff, yx_ff, s_ff;

   function automatic logic signed [16:0] to_q14(input logic [DATA_WIDTH-1:0] r);
      logic signed [DATA_WIDTH+16:0] e;
      e = {{17{r[DATA_WIDTH-1]}}, r};
      if (DATA_WIDTH >= 16) return 17'(e >>> (DATA_WIDTH - 16));
      else                  return 17'(e <<< (16 - DATA_WIDTH));
   endfunction

   assign w_q = to_q14(quat_w);
   assign x_q = to_q14(quat_x);
   assign y_q = to_q14(quat_y);
   assign z_q = to_q14(quat_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      wx_ff <= w_q * x_q;  yz_ff <= y_q * z_q;
      xx_ff <= x_q * x_q;  yy_ff <= y_q * y_q;
      wz_ff <= w_q * z_q;  xy_ff <= x_q * y_q;
      zz_ff <= z_q * z_q;  wy_ff <= w_q * y_q;
      zx_ff <= z_q * x_q;
      ry_ff  <= PROD_W'(wx_ff + yz_ff) <<< 1;
      rx_ff  <= ONE_Q28 - (PROD_W'(xx_ff + yy_ff) <<< 1);
      yy2_ff <= PROD_W'(wz_ff + xy_ff) <<< 1;
      yx_ff  <= ONE_Q28 - (PROD_W'(yy_ff + zz_ff) <<< 1);
      s_ff   <= PROD_W'(wy_ff - zx_ff) <<< 1;
   end

   assign out_valid = v2_ff;
   assign roll_y = ry_ff;
   assign roll_x = rx_ff;
   assign yaw_y  = yy2_ff;
   assign yaw_x  = yx_ff;
   assign sine   = s_ff;
endmodule
`default_nettype wire

// ----- src/q2e_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root of 2^56 - s^2, one result bit per stage.
// Also carries the roll and yaw arguments alongside so all lanes stay aligned.
module q2e_sqrt (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic signed [q2e_pkg::PROD_W-1:0] roll_y,
   input  wire logic signed [q2e_pkg::PROD_W-1:0] roll_x,
   input  wire logic signed [q2e_pkg::PROD_W-1:0] yaw_y,
   input  wire logic signed [q2e_pkg::PROD_W-1:0] yaw_x,
   input  wire logic signed [q2e_pkg::PROD_W-1:0] sine,
   output logic out_valid,
   output q2e_pkg::lane_type roll_lane,
   output q2e_pkg::lane_type yaw_lane,
   output q2e_pkg::lane_type pitch_lane,
   output logic pitch_clamp
);
   import q2e_pkg::*;

   localparam int NST = ROOT_W; // result bits
   localparam int REM_W = RAD_W + 2;

   // stage 0 registers: square of s
   logic v0_ff;
   logic signed [PROD_W-1:0] ry0_ff, rx0_ff, yy0_ff, yx0_ff, s0_ff;
   logic [RAD_W-1:0] sq_ff;
   logic signed [PROD_W-1:0] s_abs;

   assign s_abs = sine[PROD_W-1] ? -sine : sine;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= in_valid;
      ry0_ff <= roll_y; rx0_ff <= roll_x; yy0_ff <= yaw_y; yx0_ff <= yaw_x;
      s0_ff  <= sine;
      // only used when |s| < 2^28, so 29-bit operands suffice
      sq_ff  <= RAD_W'(s_abs[28:0]) * RAD_W'(s_abs[28:0]);
   end

   logic clamp0;
   assign clamp0 = (s0_ff >= ONE_Q28) || (s0_ff <= -ONE_Q28);

   // digit stages
   logic [REM_W-1:0] rem_ff [NST+1];
   logic [RAD_W-1:0] rad_ff [NST+1];
   logic [ROOT_W-1:0] root_ff [NST+1];
   logic v_ff [NST+1];
   logic cl_ff [NST+1];
   logic signed [PROD_W-1:0] ry_ff [NST+1], rx_ff [NST+1], yy_ff [NST+1],
                             yx_ff [NST+1], s_ff [NST+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= v0_ff;
      rad_ff[0]  <= clamp0 ? '0 : ((RAD_W'(1) << 56) - sq_ff);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      cl_ff[0]   <= clamp0;
      ry_ff[0] <= ry0_ff; rx_ff[0] <= rx0_ff; yy_ff[0] <= yy0_ff; yx_ff[0] <= yx0_ff;
      s_ff[0]  <= s0_ff;
   end

   for (genvar i = 0; i < NST; i++) begin : g_dig
      logic [REM_W-1:0] r_sh, trial;
      assign r_sh  = {rem_ff[i][REM_W-3:0], rad_ff[i][RAD_W-1 -: 2]};
      assign trial = REM_W'({root_ff[i], 2'b01});
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
         rad_ff[i+1] <= rad_ff[i] << 2;
         if (r_sh >= trial) begin
            rem_ff[i+1]  <= r_sh - trial;
            root_ff[i+1] <= {root_ff[i][ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i+1]  <= r_sh;
            root_ff[i+1] <= {root_ff[i][ROOT_W-2:0], 1'b0};
         end
         cl_ff[i+1] <= cl_ff[i];
         ry_ff[i+1] <= ry_ff[i]; rx_ff[i+1] <= rx_ff[i];
         yy_ff[i+1] <= yy_ff[i]; yx_ff[i+1] <= yx_ff[i];
         s_ff[i+1]  <= s_ff[i];
      end
   end

   assign out_valid = v_ff[NST];
   assign pitch_clamp = cl_ff[NST];
   always_comb begin
      roll_lane.x  = CX_W'(rx_ff[NST]);
      roll_lane.y  = CX_W'(ry_ff[NST]);
      roll_lane.z  = '0;
      roll_lane.zero = 1'b0;
      yaw_lane.x   = CX_W'(yx_ff[NST]);
      yaw_lane.y   = CX_W'(yy_ff[NST]);
      yaw_lane.z   = '0;
      yaw_lane.zero = 1'b0;
      pitch_lane.x = CX_W'(root_ff[NST]);
      pitch_lane.y = CX_W'(s_ff[NST]);
      pitch_lane.z = '0;
      pitch_lane.zero = 1'b0;
   end
endmodule
`default_nettype wire

// ----- src/q2e_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Unrolled vectoring CORDIC: a quadrant fold stage, then one stage per step.
module q2e_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire q2e_pkg::lane_type lane_in,
   output logic out_valid,
   output logic signed [q2e_pkg::ANG_W-1:0] angle
);
   import q2e_pkg::*;

   localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   lane_type st_ff [NS+1];
   logic v_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
      st_ff[0].zero <= (lane_in.x == '0) && (lane_in.y == '0);
      if (lane_in.x[CX_W-1]) begin
         st_ff[0].x <= -lane_in.x;
         st_ff[0].y <= -lane_in.y;
         st_ff[0].z <= lane_in.y[CX_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
         st_ff[0] .x <= lane_in.x;
         st_ff[0].y <= lane_in.y;
         st_ff[0].z <= '0;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam logic signed [ANG_W-1:0] AT = ANG_W'(atan_q30(i));
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
         st_ff[i+1].zero <= st_ff[i].zero;
         if (!st_ff[i].y[CX_W-1]) begin
            st_ff[i+1].x <= st_ff[i].x + (st_ff[i].y >>> i);
            st_ff[i+1].y <= st_ff[i].y - (st_ff[i].x >>> i);
            st_ff[i+1].z <= st_ff[i].z + AT;
         end else begin
            st_ff[i+1].x <= st_ff[i].x - (st_ff[i].y >>> i);
            st_ff[i+1].y <= st_ff[i].y + (st_ff[i].x >>> i);
            st_ff[i+1].z <= st_ff[i].z - AT;
         end
      end
   end

   assign out_valid = v_ff[NS];
   assign angle = st_ff[NS].zero ? '0 : st_ff[NS].z;
endmodule
`default_nettype wire
